FILE: rtl/cmc_pkg.sv
// Package for the circular mosaic censor core.
// Holds field widths, register and operation codes, shared types and helpers.
// No dependencies.
package cmc_pkg;

  localparam int unsigned HUE_W   = 15;
  localparam int unsigned CH_W    = 16;
  localparam int unsigned PIX_W   = HUE_W + 3 * CH_W;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned HUE_LSB = 0;
  localparam int unsigned SAT_LSB = HUE_LSB + HUE_W;
  localparam int unsigned LUM_LSB = SAT_LSB + CH_W;
  localparam int unsigned ALP_LSB = LUM_LSB + CH_W;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 64;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int unsigned DEF_FRAME_WIDTH  = 256;
  localparam int unsigned DEF_FRAME_HEIGHT = 256;
  localparam int unsigned DEF_MAX_BLOCK    = 16;

  typedef struct packed {
    logic [4:0] block_width;
    logic [7:0] center_x;
    logic [7:0] center_y;
    logic [8:0] radius;
  } cmc_cfg_t;

  typedef struct packed {
    logic             done;
    logic             censor;
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
  } cmc_geom_t;

  function automatic logic [15:0] clamp_coord(logic [15:0] v, logic [15:0] lim);
    return (v >= lim) ? (lim - 16'd1) : v;
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: rtl/cmc_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module cmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cmc_geom.sv
// Block-corner and circle tests for the mosaic censor.
// Serial remainder for block alignment, then one shared multiplier for the squares.
// Depends on cmc_pkg.
module cmc_geom #(
  parameter int unsigned BW_W = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [7:0]             px_i,
  input  logic [7:0]             py_i,
  input  logic [BW_W-1:0]        bw_i,
  input  cmc_pkg::cmc_cfg_t      cfg_i,
  output cmc_pkg::cmc_geom_t     geom_o
);
  import cmc_pkg::*;

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_DIV  = 2'd1;
  localparam logic [1:0] G_MUL  = 2'd2;
  localparam logic [1:0] G_FIN  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [7:0]       px_q, py_q;
  logic [BW_W-1:0]  rem_q, rx_q, ry_q, rem_next;
  logic [19:0]      dblk_q, reach2_q, dpix_q, r2_q;
  logic             bit_sel, ge;
  logic [BW_W:0]    trial;
  logic [7:0]       bx, by;
  logic [9:0]       op, reach;
  logic [19:0]      prod;

  assign bit_sel  = cnt_q[3] ? py_q[3'd7 - cnt_q[2:0]] : px_q[3'd7 - cnt_q[2:0]];
  assign trial    = {rem_q, bit_sel};
  assign ge       = (trial >= {1'b0, bw_i});
  assign rem_next = ge ? BW_W'(trial - {1'b0, bw_i}) : trial[BW_W-1:0];

  assign bx    = px_q - 8'(rx_q);
  assign by    = py_q - 8'(ry_q);
  assign reach = 10'(cfg_i.radius) + 10'({bw_i, 1'b0});

  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    op = 10'(abs_diff(bx, cfg_i.center_x));
      3'd1:    op = 10'(abs_diff(by, cfg_i.center_y));
      3'd2:    op = reach;
      3'd3:    op = 10'(abs_diff(px_q, cfg_i.center_x));
      3'd4:    op = 10'(abs_diff(py_q, cfg_i.center_y));
      default: op = 10'(cfg_i.radius);
    endcase
  end

  assign prod = 20'(op) * 20'(op);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      G_IDLE: begin
        if (start_i) begin
          state_d = G_DIV;
          cnt_d   = 4'd0;
        end
      end
      G_DIV: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = G_MUL;
          cnt_d   = 4'd0;
        end
      end
      G_MUL: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          state_d = G_FIN;
        end
      end
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == G_IDLE && start_i) begin
      px_q   <= px_i;
      py_q   <= py_i;
      rem_q  <= '0;
      dblk_q <= '0;
      dpix_q <= '0;
    end
    if (state_q == G_DIV) begin
      rem_q <= (cnt_q[2:0] == 3'd7) ? '0 : rem_next;
      if (cnt_q == 4'd7) begin
        rx_q <= rem_next;
      end
      if (cnt_q == 4'd15) begin
        ry_q <= rem_next;
      end
    end
    if (state_q == G_MUL) begin
      unique case (cnt_q[2:0])
        3'd0, 3'd1: dblk_q   <= dblk_q + prod;
        3'd2:       reach2_q <= prod;
        3'd3, 3'd4: dpix_q   <= dpix_q + prod;
        default:    r2_q     <= prod;
      endcase
    end
  end

  assign geom_o.done   = (state_q == G_FIN);
  assign geom_o.censor = (dblk_q <= reach2_q) && (dpix_q <= r2_q);
  assign geom_o.bx     = bx;
  assign geom_o.by     = by;

endmodule

FILE: rtl/cmc_div.sv
// Four-lane restoring divider, one quotient bit per lane per cycle.
// Divides the block sums by the block area; depends on nothing but its ports.
module cmc_div #(
  parameter int unsigned SUM_W  = 26,
  parameter int unsigned AREA_W = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [3:0][SUM_W-1:0]  num_i,
  input  logic [AREA_W-1:0]      den_i,
  output logic                   done_o,
  output logic [3:0][SUM_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [3:0][SUM_W-1:0] num_q;
  logic [3:0][AREA_W-1:0] rem_q;
  logic [3:0][AREA_W:0]  trial;
  logic [3:0]            ge;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      trial[k] = {rem_q[k], num_q[k][SUM_W-1]};
      ge[k]    = (trial[k] >= {1'b0, den_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      for (int k = 0; k < 4; k++) begin
        rem_q[k] <= ge[k] ? AREA_W'(trial[k] - {1'b0, den_i}) : trial[k][AREA_W-1:0];
        num_q[k] <= {num_q[k][SUM_W-2:0], ge[k]};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

FILE: rtl/circular_mosaic_censor_core.sv
// Circular mosaic censor: pixel store with block-average reads inside a circle.
// Instantiates cmc_ram, cmc_geom and cmc_div; depends on cmc_pkg.
//
//  channel   | dir | handshake                  | content
//  s_axis    | in  | s_axis_tvalid/tready       | tuser operation, tdata position and pixel
//  m_axis    | out | m_axis_tvalid/tready       | tuser was_censored, tdata colour
//  cfg       | in  | cfg_valid_i/cfg_ready_o    | register index, write data
//
// A write is stored as soon as it is accepted. A read first runs alignment and
// squaring in the geometry unit, then either a single store read for the plain pixel or
// bw*bw store reads (one per cycle on the single read port) and a divide of the block
// sums by the block area, and then loads the output register.
// Output register frees the input side while a result waits; stalls on m_axis only hold
// the block when a second result is ready. Reset clears control and config, not the store.
module circular_mosaic_censor_core #(
  parameter int unsigned FRAME_WIDTH  = cmc_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT = cmc_pkg::DEF_FRAME_HEIGHT,
  parameter int unsigned MAX_BLOCK    = cmc_pkg::DEF_MAX_BLOCK
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x[7:0], pos_y[15:8], in_hue[30:16], in_sat[46:31], in_lum[62:47], in_alpha[78:63]
  input  logic [cmc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_hue[14:0], out_sat[30:15], out_lum[46:31], out_alpha[62:47]
  output logic [cmc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // was_censored
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cmc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import cmc_pkg::*;

  localparam int unsigned DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BW_W   = $clog2(MAX_BLOCK + 1);
  localparam int unsigned AREA_W = 2 * BW_W;
  localparam int unsigned SUM_W  = CH_W + AREA_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GEOM   = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_FLUSH  = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DWAIT  = 4'd5;
  localparam logic [3:0] S_SINGLE = 4'd6;
  localparam logic [3:0] S_SGET   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]            state_q, state_d;
  cmc_cfg_t              cfg_q;
  logic [7:0]            bw_sat;
  logic [BW_W-1:0]       bw;
  logic [AREA_W-1:0]     area;
  logic                  in_acc, wr_en, rd_en, rd_pend_q;
  logic [7:0]            in_px, in_py;
  logic [7:0]            px_q, py_q, px_cl, py_cl;
  logic [BW_W-1:0]       ci_q, cj_q;
  logic                  last_rd;
  logic [15:0]           col, row;
  logic [31:0]           waddr32, raddr32;
  logic [PIX_W-1:0]      rdata;
  logic [3:0][SUM_W-1:0] acc_q, quot;
  logic                  div_done;
  cmc_geom_t             geom;
  logic [PIX_W-1:0]      res_q;
  logic                  res_cens_q;
  logic                  out_valid_q, out_user_q;
  logic [PIX_W-1:0]      out_data_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_width <= 5'd1;
      cfg_q.center_x    <= 8'd0;
      cfg_q.center_y    <= 8'd0;
      cfg_q.radius      <= 9'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_WIDTH: cfg_q.block_width <= cfg_data_i[4:0];
        CFG_CENTER_X:    cfg_q.center_x    <= cfg_data_i[7:0];
        CFG_CENTER_Y:    cfg_q.center_y    <= cfg_data_i[7:0];
        CFG_RADIUS:      cfg_q.radius      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_q.block_width == 5'd0) begin
      bw_sat = 8'd1;
    end else if (8'(cfg_q.block_width) > 8'(MAX_BLOCK)) begin
      bw_sat = 8'(MAX_BLOCK);
    end else begin
      bw_sat = 8'(cfg_q.block_width);
    end
  end

  assign bw   = bw_sat[BW_W-1:0];
  assign area = AREA_W'(bw) * AREA_W'(bw);

  // input side
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_px         = s_axis_tdata[7:0];
  assign in_py         = s_axis_tdata[15:8];
  assign px_cl = 8'(clamp_coord(16'(in_px), 16'(FRAME_WIDTH)));
  assign py_cl = 8'(clamp_coord(16'(in_py), 16'(FRAME_HEIGHT)));

  assign wr_en = in_acc && (s_axis_tuser == OP_WRITE)
              && (16'(in_px) < 16'(FRAME_WIDTH)) && (16'(in_py) < 16'(FRAME_HEIGHT));
  assign waddr32 = 32'(in_py) * 32'(FRAME_WIDTH) + 32'(in_px);

  // store read address
  assign last_rd = (ci_q == bw - BW_W'(1)) && (cj_q == bw - BW_W'(1));

  always_comb begin
    if (state_q == S_ACC) begin
      col = clamp_coord(16'(geom.bx) + 16'(ci_q), 16'(FRAME_WIDTH));
      row = clamp_coord(16'(geom.by) + 16'(cj_q), 16'(FRAME_HEIGHT));
    end else begin
      col = 16'(px_q);
      row = 16'(py_q);
    end
  end

  assign raddr32 = 32'(row) * 32'(FRAME_WIDTH) + 32'(col);
  assign rd_en   = (state_q == S_ACC) || (state_q == S_SINGLE);

  cmc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr32[AW-1:0]),
    .wdata_i (s_axis_tdata[16 +: PIX_W]),
    .re_i    (rd_en),
    .raddr_i (raddr32[AW-1:0]),
    .rdata_o (rdata)
  );

  cmc_geom #(
    .BW_W (BW_W)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (s_axis_tuser == OP_READ)),
    .px_i    (px_cl),
    .py_i    (py_cl),
    .bw_i    (bw),
    .cfg_i   (cfg_q),
    .geom_o  (geom)
  );

  cmc_div #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DSTART),
    .num_i   (acc_q),
    .den_i   (area),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && (s_axis_tuser == OP_READ)) state_d = S_GEOM;
      S_GEOM:   if (geom.done) state_d = geom.censor ? S_ACC : S_SINGLE;
      S_ACC:    if (last_rd) state_d = S_FLUSH;
      S_FLUSH:  state_d = S_DSTART;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT:  if (div_done) state_d = S_OUT;
      S_SINGLE: state_d = S_SGET;
      S_SGET:   state_d = S_OUT;
      S_OUT:    if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      ci_q        <= '0;
      cj_q        <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == S_ACC);
      if (state_q == S_GEOM) begin
        ci_q <= '0;
        cj_q <= '0;
      end else if (state_q == S_ACC) begin
        if (ci_q == bw - BW_W'(1)) begin
          ci_q <= '0;
          cj_q <= cj_q + BW_W'(1);
        end else begin
          ci_q <= ci_q + BW_W'(1);
        end
      end
      if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= px_cl;
      py_q <= py_cl;
    end
    if (state_q == S_GEOM) begin
      acc_q <= '0;
    end else if (rd_pend_q) begin
      acc_q[0] <= acc_q[0] + SUM_W'(rdata[HUE_LSB +: HUE_W]);
      acc_q[1] <= acc_q[1] + SUM_W'(rdata[SAT_LSB +: CH_W]);
      acc_q[2] <= acc_q[2] + SUM_W'(rdata[LUM_LSB +: CH_W]);
      acc_q[3] <= acc_q[3] + SUM_W'(rdata[ALP_LSB +: CH_W]);
    end
    if (state_q == S_DWAIT && div_done) begin
      res_q      <= {quot[3][CH_W-1:0], quot[2][CH_W-1:0],
                     quot[1][CH_W-1:0], quot[0][HUE_W-1:0]};
      res_cens_q <= 1'b1;
    end else if (state_q == S_SGET) begin
      res_q      <= rdata;
      res_cens_q <= 1'b0;
    end
    if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= res_q;
      out_user_q <= res_cens_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};
  assign m_axis_tuser  = out_user_q;

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_IDLE))
    else $error("store write outside idle");

  a_geom_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom.done |-> (state_q == S_GEOM))
    else $error("geometry result with no read pending");

  a_rd_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q) == S_ACC))
    else $error("accumulate without block read");

  a_div_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWAIT && div_done) |=> (state_q == S_OUT && res_cens_q))
    else $error("block average not flagged as censored");

endmodule
